FILE: design/tfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfe_pkg: shared types and constants of the tab field escape encoder
// Opcodes, character codes, the escape function and the job descriptor that
// travels from the classifier through the queue to the byte drain.
// ----------------------------------------------------------------------------
package tfe_pkg;

  localparam logic [1:0] OP_BYTE       = 2'd0;
  localparam logic [1:0] OP_END_FIELD  = 2'd1;
  localparam logic [1:0] OP_END_RECORD = 2'd2;

  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_UPPER_N   = 8'h4E;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_LOWER_X   = 8'h78;
  localparam logic [7:0] CH_PRINT_LO  = 8'h20;
  localparam logic [7:0] CH_PRINT_HI  = 8'h7E;

  localparam int JOB_BYTES = 5;
  localparam int QUEUE_DEPTH = 4;

  // escaped form of one byte, up to four characters, b[0] first
  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      n;
  } esc_t;

  // all result bytes of one item, bytes[0] first, len in 1..5
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [2:0]                len;
  } job_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'd0, v};
    end else begin
      r = 8'h61 + {4'd0, v} - 8'd10;
    end
    return r;
  endfunction

  function automatic esc_t escape_byte(input logic [7:0] c);
    esc_t e;
    e.b = '0;
    e.n = 3'd2;
    e.b[0] = CH_BACKSLASH;
    case (c)
      CH_BACKSLASH: e.b[1] = CH_BACKSLASH;
      CH_TAB:       e.b[1] = CH_LOWER_T;
      CH_LF:        e.b[1] = CH_LOWER_N;
      CH_CR:        e.b[1] = CH_LOWER_R;
      default: begin
        if (c >= CH_PRINT_LO && c <= CH_PRINT_HI) begin
          e.b[0] = c;
          e.n    = 3'd1;
        end else begin
          e.b[1] = CH_LOWER_X;
          e.b[2] = hex_digit(c[7:4]);
          e.b[3] = hex_digit(c[3:0]);
          e.n    = 3'd4;
        end
      end
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

FILE: design/tfe_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfe_front: item classifier
// Holds the column and field state, applies the field limit and turns each
// accepted item into one job descriptor holding every byte it produces.
// ----------------------------------------------------------------------------
module tfe_front #(
  parameter int LIMIT_WIDTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output logic               item_stall,
  input  wire logic [1:0]    opcode,
  input  wire logic [7:0]    data_byte,
  input  wire logic [15:0]   field_limit,
  input  wire logic          queue_full,
  output logic               push,
  output tfe_pkg::job_t      job
);
  import tfe_pkg::*;

  logic                   later_column, later_column_next;
  logic                   field_open, field_open_next;
  logic [LIMIT_WIDTH-1:0] field_count, field_count_next;

  logic                   accept;
  logic [LIMIT_WIDTH-1:0] limit_m;
  logic [LIMIT_WIDTH-1:0] count_base;
  logic                   emit;
  logic                   tab;
  esc_t                   pay;

  assign item_stall = queue_full;
  assign accept     = item_valid && !queue_full;
  assign limit_m    = LIMIT_WIDTH'(field_limit);

  always_comb begin
    later_column_next = later_column;
    field_open_next   = field_open;
    field_count_next  = field_count;
    emit              = 1'b0;
    tab               = 1'b0;
    pay               = '0;
    count_base        = field_open ? field_count : '0;
    unique case (opcode)
      OP_BYTE: begin
        // past the limit of an open field: dropped, state untouched
        if (!(field_open && limit_m != '0 && field_count >= limit_m)) begin
          emit = 1'b1;
          if (!field_open) begin
            tab               = later_column;
            later_column_next = 1'b1;
            field_open_next   = 1'b1;
          end
          field_count_next = (count_base == '1) ? count_base : count_base + 1'b1;
          pay = escape_byte(data_byte);
        end
      end
      OP_END_FIELD: begin
        if (!field_open) begin
          emit              = 1'b1;
          tab               = later_column;
          later_column_next = 1'b1;
          pay.b[0]          = CH_BACKSLASH;
          pay.b[1]          = CH_UPPER_N;
          pay.n             = 3'd2;
        end
        field_open_next  = 1'b0;
        field_count_next = '0;
      end
      OP_END_RECORD: begin
        emit              = 1'b1;
        pay.b[0]          = CH_LF;
        pay.n             = 3'd1;
        later_column_next = 1'b0;
        field_open_next   = 1'b0;
        field_count_next  = '0;
      end
      default: begin
      end
    endcase
  end

  // place the optional tab ahead of the escaped text
  always_comb begin
    job.bytes[0] = tab ? CH_TAB : pay.b[0];
    for (int i = 1; i < 4; i++) begin
      job.bytes[i] = tab ? pay.b[i-1] : pay.b[i];
    end
    job.bytes[4] = tab ? pay.b[3] : 8'h00;
    job.len      = pay.n + {2'b00, tab};
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      later_column <= 1'b0;
      field_open   <= 1'b0;
      field_count  <= '0;
    end else if (accept) begin
      later_column <= later_column_next;
      field_open   <= field_open_next;
      field_count  <= field_count_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/tfe_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfe_queue: job queue
// Short FIFO of job descriptors between the classifier and the byte drain.
// ----------------------------------------------------------------------------
module tfe_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire tfe_pkg::job_t push_job,
  input  wire logic          pop,
  output logic               full,
  output logic               empty,
  output tfe_pkg::job_t      head
);
  import tfe_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  job_t          mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full  = (count == (PW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/tfe_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfe_back: byte drain
// Walks the head job one byte per cycle, while the output is not stalled,
// into the output register and retires the job on its final beat.
// ----------------------------------------------------------------------------
module tfe_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          empty,
  input  wire tfe_pkg::job_t head,
  output logic               pop,
  output logic               beat_valid,
  input  wire logic          beat_stall,
  output logic [7:0]         out_byte,
  output logic               last_of_run
);
  import tfe_pkg::*;

  logic [2:0] idx;
  logic       load;
  logic       final_byte;

  assign load       = !empty && (!beat_valid || !beat_stall);
  assign final_byte = (idx == head.len - 3'd1);
  assign pop        = load && final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
      idx        <= '0;
    end else begin
      if (load) begin
        beat_valid <= 1'b1;
        idx        <= final_byte ? 3'd0 : idx + 3'd1;
      end else if (!beat_stall) begin
        beat_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= head.bytes[idx];
      last_of_run <= final_byte;
    end
  end

endmodule
`default_nettype wire

FILE: design/tab_field_escape_encoder.sv
// The first beat of an item passes the job queue and then the output register.
// One item per cycle while each item yields at most one byte and neither port
// stalls; the output port moves one byte per cycle, so a longer item holds it for each of its bytes.
// A 4-entry job queue lets the classifier run ahead of the output drain.
// Reset (rst, synchronous): first column, no field open, count 0, queue and
// output register empty.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tab_field_escape_encoder: top level
// Escapes text fields into one tab-separated record, one input byte per item.
// ----------------------------------------------------------------------------
module tab_field_escape_encoder #(
  parameter int LIMIT_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [7:0]  data_byte,
  input  wire logic [15:0] field_limit,
  output logic             beat_valid,
  input  wire logic        beat_stall,
  output logic [7:0]       out_byte,
  output logic             last_of_run
);
  import tfe_pkg::*;

  logic push;
  logic pop;
  logic full;
  logic empty;
  job_t push_job;
  job_t head;

  tfe_front #(
    .LIMIT_WIDTH(LIMIT_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .opcode     (opcode),
    .data_byte  (data_byte),
    .field_limit(field_limit),
    .queue_full (full),
    .push       (push),
    .job        (push_job)
  );

  tfe_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .full    (full),
    .empty   (empty),
    .head    (head)
  );

  tfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (empty),
    .head       (head),
    .pop        (pop),
    .beat_valid (beat_valid),
    .beat_stall (beat_stall),
    .out_byte   (out_byte),
    .last_of_run(last_of_run)
  );

endmodule
`default_nettype wire

FILE: tb/sv/tb_tab_field_escape_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tab_field_escape_encoder: testbench of the tab field escape encoder
// Sends opcode/byte/limit items and keeps its own copy of the column and field
// state to work out the escaped record text. Every output beat is checked in
// order against that text, with random stalls on both ports.
// ----------------------------------------------------------------------------
module tb_tab_field_escape_encoder;
  import tfe_pkg::*;

  localparam logic [1:0]  OP_IGNORED   = 2'd3;
  localparam logic [7:0]  CH_DIGIT_0   = 8'h30;
  localparam logic [7:0]  CH_LOWER_A   = 8'h61;
  localparam logic [7:0]  CH_UPPER_A   = 8'h41;
  localparam logic [7:0]  CH_UPPER_Z   = 8'h5A;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
  localparam int          RANDOM_ITEMS = 175;
  localparam int          QUIET_LIMIT  = 1000;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          REPORT_LINES = 40;

  typedef struct packed {
    logic [7:0] text;
    logic       last;
  } text_beat_t;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  logic [1:0]  opcode;
  logic [7:0]  data_byte;
  logic [15:0] field_limit;
  logic        beat_valid;
  logic        beat_stall;
  logic [7:0]  out_byte;
  logic        last_of_run;

  // escaped text still owed by the block, oldest first
  text_beat_t  pending_text[$];

  // mirrored encoder state
  logic        later_column_m;
  logic        field_open_m;
  logic [15:0] field_count_m;

  bit          in_idle_on;
  bit          out_idle_on;
  int          mismatch_count;
  int          items_sent;
  int          out_stall_left;
  int          quiet_cycles = 0;

  tab_field_escape_encoder dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .opcode      (opcode),
    .data_byte   (data_byte),
    .field_limit (field_limit),
    .beat_valid  (beat_valid),
    .beat_stall  (beat_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CH_DIGIT_0 + {4'd0, nib};
    end else begin
      c = CH_LOWER_A + {4'd0, nib} - 8'd10;
    end
    return c;
  endfunction

  // Text the block should emit for one accepted item; updates the mirror.
  task automatic encode_item(input logic [1:0] op, input logic [7:0] db,
                             input logic [15:0] lim);
    logic [7:0] run[$];
    text_beat_t beat;
    case (op)
      OP_BYTE: begin
        if (!(field_open_m && lim != 16'd0 && field_count_m >= lim)) begin
          if (!field_open_m) begin
            if (later_column_m) run = {run, CH_TAB};
            later_column_m = 1'b1;
            field_open_m   = 1'b1;
            field_count_m  = '0;
          end
          if (field_count_m != COUNT_MAX) field_count_m++;
          case (db)
            CH_BACKSLASH: run = {run, CH_BACKSLASH, CH_BACKSLASH};
            CH_TAB:       run = {run, CH_BACKSLASH, CH_LOWER_T};
            CH_LF:        run = {run, CH_BACKSLASH, CH_LOWER_N};
            CH_CR:        run = {run, CH_BACKSLASH, CH_LOWER_R};
            default: begin
              if (db >= CH_PRINT_LO && db <= CH_PRINT_HI) begin
                run = {run, db};
              end else begin
                run = {run, CH_BACKSLASH, CH_LOWER_X,
                       hex_char(db[7:4]), hex_char(db[3:0])};
              end
            end
          endcase
        end
      end
      OP_END_FIELD: begin
        if (!field_open_m) begin
          if (later_column_m) run = {run, CH_TAB};
          later_column_m = 1'b1;
          run = {run, CH_BACKSLASH, CH_UPPER_N};
        end
        field_open_m  = 1'b0;
        field_count_m = '0;
      end
      OP_END_RECORD: begin
        run = {run, CH_LF};
        later_column_m = 1'b0;
        field_open_m   = 1'b0;
        field_count_m  = '0;
      end
      default: ;
    endcase
    foreach (run[i]) begin
      beat.text = run[i];
      beat.last = (i == run.size() - 1);
      pending_text = {pending_text, beat};
    end
  endtask

  task automatic report_mismatch(input string what);
    // quiet after the first few lines, but keep counting
    if (mismatch_count < REPORT_LINES) $display("%0t ns mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic send_item(input logic [1:0] op, input logic [7:0] db,
                           input logic [15:0] lim);
    @(negedge clk);
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    item_valid  <= 1'b1;
    opcode      <= op;
    data_byte   <= db;
    field_limit <= lim;
    do @(posedge clk); while (item_stall);
    encode_item(op, db, lim);
    if (op != OP_IGNORED) items_sent++;
  endtask

  function automatic logic [7:0] pick_text_byte();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: c = 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
      4: begin
        case ($urandom_range(0, 3))
          0:       c = CH_BACKSLASH;
          1:       c = CH_TAB;
          2:       c = CH_LF;
          default: c = CH_CR;
        endcase
      end
      default: c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  function automatic logic [15:0] pick_limit();
    logic [15:0] lim;
    case ($urandom_range(0, 7))
      0, 1, 2: lim = 16'd0;
      3:       lim = 16'($urandom_range(0, 65535));
      default: lim = 16'($urandom_range(1, 5));
    endcase
    return lim;
  endfunction

  // output side: check each beat against the oldest owed character
  always @(posedge clk) begin
    text_beat_t want;
    if (!rst && beat_valid && !beat_stall) begin
      if (pending_text.size() == 0) begin
        report_mismatch($sformatf("beat %h last %b with nothing owed",
                                  out_byte, last_of_run));
      end else begin
        want = pending_text.pop_front();
        if (out_byte !== want.text)
          report_mismatch($sformatf("out_byte %h, want %h", out_byte, want.text));
        if (last_of_run !== want.last)
          report_mismatch($sformatf("last_of_run %b, want %b on %h",
                                    last_of_run, want.last, want.text));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (beat_valid && !beat_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver stalls in random bursts
  initial begin
    beat_stall     = 1'b0;
    out_stall_left = 0;
    forever begin
      @(negedge clk);
      if (out_stall_left > 0) begin
        beat_stall <= 1'b1;
        out_stall_left--;
      end else if (out_idle_on && $urandom_range(0, 4) == 0) begin
        beat_stall <= 1'b1;
        out_stall_left = $urandom_range(0, 2);
      end else begin
        beat_stall <= 1'b0;
      end
    end
  end

  task automatic test_plain_text();
    send_item(OP_BYTE, CH_UPPER_A, 16'd0);
    send_item(OP_BYTE, CH_PRINT_LO, COUNT_MAX);
    send_item(OP_BYTE, CH_PRINT_HI, 16'd0);
    send_item(OP_END_FIELD, 8'hFF, COUNT_MAX);
  endtask

  task automatic test_escapes();
    // opens a later column with a hex escape: tab plus four characters
    send_item(OP_BYTE, 8'hFF, 16'd0);
    send_item(OP_BYTE, CH_BACKSLASH, 16'd0);
    send_item(OP_BYTE, CH_TAB, 16'd0);
    send_item(OP_BYTE, CH_LF, 16'd0);
    send_item(OP_BYTE, CH_CR, 16'd0);
    send_item(OP_BYTE, 8'h00, 16'd0);
    send_item(OP_BYTE, 8'h1F, 16'd0);
    send_item(OP_BYTE, 8'h7F, 16'd0);
    send_item(OP_BYTE, 8'h80, 16'd0);
    send_item(OP_END_FIELD, 8'h00, 16'd0);
  endtask

  task automatic test_field_limit();
    send_item(OP_BYTE, CH_LOWER_A, 16'd1);
    send_item(OP_BYTE, CH_LOWER_A + 8'd1, 16'd1);
    send_item(OP_BYTE, 8'h00, 16'd1);
    send_item(OP_END_FIELD, 8'($urandom), 16'($urandom));
  endtask

  task automatic test_empty_fields();
    send_item(OP_END_FIELD, 8'($urandom), 16'($urandom));
    send_item(OP_END_RECORD, 8'($urandom), 16'($urandom));
    send_item(OP_END_FIELD, 8'($urandom), 16'($urandom));
  endtask

  task automatic test_record_with_open_field();
    send_item(OP_BYTE, CH_LOWER_X, 16'd0);
    send_item(OP_END_RECORD, 8'($urandom), 16'($urandom));
  endtask

  task automatic test_ignored_opcode();
    send_item(OP_IGNORED, 8'hFF, COUNT_MAX);
    send_item(OP_IGNORED, 8'h00, 16'd0);
  endtask

  task automatic test_random_records();
    int          stop_at;
    int          fields;
    int          bytes_n;
    logic [15:0] lim;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 4))
          send_item(2'($urandom), 8'($urandom), 16'($urandom));
      end else begin
        fields = $urandom_range(1, 5);
        for (int f = 0; f < fields; f++) begin
          lim     = pick_limit();
          bytes_n = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
          for (int b = 0; b < bytes_n; b++) begin
            if ($urandom_range(0, 9) == 0) lim = pick_limit();
            send_item(OP_BYTE, pick_text_byte(), lim);
          end
          // now and then the record ends with its last field still open
          if (f < fields - 1 || $urandom_range(0, 7) != 0)
            send_item(OP_END_FIELD, 8'($urandom), 16'($urandom));
        end
        send_item(OP_END_RECORD, 8'($urandom), 16'($urandom));
      end
    end
  endtask

  // no idling on either side, so plain text can move one beat per cycle
  task automatic test_full_rate();
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    repeat (20) send_item(OP_BYTE, 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z)), 16'd0);
    send_item(OP_END_RECORD, 8'($urandom), 16'($urandom));
  endtask

  initial begin
    rst            = 1'b1;
    item_valid     = 1'b0;
    opcode         = OP_BYTE;
    data_byte      = '0;
    field_limit    = '0;
    in_idle_on     = 1'b0;
    out_idle_on    = 1'b0;
    mismatch_count = 0;
    items_sent     = 0;
    later_column_m = 1'b0;
    field_open_m   = 1'b0;
    field_count_m  = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;

    test_plain_text();
    test_escapes();
    test_field_limit();
    test_empty_fields();
    test_record_with_open_field();
    test_ignored_opcode();
    test_random_records();
    test_full_rate();

    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_text.size() != 0)
      report_mismatch($sformatf("%0d beats never arrived", pending_text.size()));
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: tab_field_escape_encoder.f
design/tfe_pkg.sv
design/tfe_front.sv
design/tfe_queue.sv
design/tfe_back.sv
design/tab_field_escape_encoder.sv
tb/sv/tb_tab_field_escape_encoder.sv
